// ----- rtl/rp4d_pkg.sv -----
// Package for the 4D vertex rotate/project pipeline.
// Holds field widths, register map codes, reset values and divider sizes.
// No dependencies.
package rp4d_pkg;

    localparam int COORD_W  = 16;
    localparam int TRIG_W   = 16;
    localparam int CENTER_W = 12;
    localparam int SCALE_W  = 16;
    localparam int SCREEN_W = 20;

    localparam int PROD_W = 32;
    localparam int ROT_W  = 33;
    localparam int D1_W   = 34;
    localparam int D2W_W  = 38;
    localparam int DEN_W  = 35;
    localparam int MAG_W  = 34;
    localparam int MUL_W  = MAG_W + SCALE_W;

    // Divider: numerator 2*mag*scale + d2, divisor 2*d2, quotient saturated to QUOT_W bits.
    localparam int NUM_W          = MUL_W + 1;
    localparam int DIV_W          = DEN_W + 1;
    localparam int QUOT_W         = 22;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

    localparam int PRE_STAGES = 5;
    localparam int PIPE_LAT   = PRE_STAGES + DIV_STAGES + 1;

    localparam int SUM_W = 24;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_COS_XW  = 3'd0;
    localparam logic [2:0] REG_SIN_XW  = 3'd1;
    localparam logic [2:0] REG_COS_YZ  = 3'd2;
    localparam logic [2:0] REG_SIN_YZ  = 3'd3;
    localparam logic [2:0] REG_CENTER_X = 3'd4;
    localparam logic [2:0] REG_CENTER_Y = 3'd5;
    localparam logic [2:0] REG_SCALE   = 3'd6;

    localparam logic [TRIG_W-1:0]   RST_COS    = 16'd16384;
    localparam logic [TRIG_W-1:0]   RST_SIN    = 16'd0;
    localparam logic [CENTER_W-1:0] RST_CX     = 12'd320;
    localparam logic [CENTER_W-1:0] RST_CY     = 12'd240;
    localparam logic [SCALE_W-1:0]  RST_SCALE  = 16'd3932;

    // w camera distance 3 in 27 fraction bits.
    localparam logic signed [D1_W-1:0] W_DIST_FIX = 34'sd402653184;

    typedef struct packed {
        logic last;
        logic behind;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_side;

endpackage

// ----- rtl/rp4d_div.sv -----
// Pipelined restoring divider, BITS_PER_STAGE quotient bits per register stage.
// The caller guarantees the quotient fits QUOT_W bits. Depends on rp4d_pkg.
module rp4d_div
    import rp4d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_den,
    output logic [QUOT_W-1:0] o_quot
);

    logic [DIV_W-1:0]  r_rem [DIV_STAGES];
    logic [QUOT_W-1:0] r_low [DIV_STAGES];
    logic [QUOT_W-1:0] r_q   [DIV_STAGES];
    logic [DIV_W-1:0]  r_den [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic [DIV_W-1:0]  s_rem_in;
            logic [QUOT_W-1:0] s_low_in;
            logic [QUOT_W-1:0] s_q_in;
            logic [DIV_W-1:0]  s_den_in;
            logic [DIV_W-1:0]  n_rem;
            logic [QUOT_W-1:0] n_low;
            logic [QUOT_W-1:0] n_q;

            if (k == 0) begin : g_first
                assign s_rem_in = DIV_W'(i_num[NUM_W-1:QUOT_W]);
                assign s_low_in = i_num[QUOT_W-1:0];
                assign s_q_in   = '0;
                assign s_den_in = i_den;
            end else begin : g_next
                assign s_rem_in = r_rem[k-1];
                assign s_low_in = r_low[k-1];
                assign s_q_in   = r_q[k-1];
                assign s_den_in = r_den[k-1];
            end

            always_comb begin
                logic [DIV_W:0] t;
                n_rem = s_rem_in;
                n_low = s_low_in;
                n_q   = s_q_in;
                for (int b = 0; b < BITS_PER_STAGE; b++) begin
                    t     = {n_rem, n_low[QUOT_W-1]};
                    n_low = {n_low[QUOT_W-2:0], 1'b0};
                    if (t >= {1'b0, s_den_in}) begin
                        t   = t - {1'b0, s_den_in};
                        n_q = {n_q[QUOT_W-2:0], 1'b1};
                    end else begin
                        n_q = {n_q[QUOT_W-2:0], 1'b0};
                    end
                    n_rem = t[DIV_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_low[k] <= n_low;
                    r_q[k]   <= n_q;
                    r_den[k] <= s_den_in;
                end
            end
        end
    endgenerate

    assign o_quot = r_q[DIV_STAGES-1];

endmodule

// ----- rtl/rotate_project_4d_vertex_top.sv -----
// Top level of the 4D vertex rotate and double perspective projection pipeline.
// Holds the APB register file, the front stages and output; uses rp4d_pkg and rp4d_div.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_vx i_vy i_vz i_vw i_last_vertex
//   output   out        o_valid / i_stall    o_screen_x o_screen_y o_behind_camera o_last_out
//   config   in         psel/penable/pready  paddr pwdata prdata
//
// One vertex per cycle unless the output stalls; the stages in order are products, rotation sums, divisors,
// numerator product, divider setup, eleven divider stages of two quotient bits, output.
// The whole pipe holds when the output beat is valid and stalled.
// Reset is synchronous, clears valid bits and loads config reset values; data registers are not reset.
module rotate_project_4d_vertex_top
    import rp4d_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [COORD_W-1:0]  i_vx,
    input  logic signed [COORD_W-1:0]  i_vy,
    input  logic signed [COORD_W-1:0]  i_vz,
    input  logic signed [COORD_W-1:0]  i_vw,
    input  logic                       i_last_vertex,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SCREEN_W-1:0] o_screen_x,
    output logic signed [SCREEN_W-1:0] o_screen_y,
    output logic                       o_behind_camera,
    output logic                       o_last_out
);

    // Register file.
    logic [TRIG_W-1:0]   r_cos_xw, r_sin_xw, r_cos_yz, r_sin_yz;
    logic [CENTER_W-1:0] r_center_x, r_center_y;
    logic [SCALE_W-1:0]  r_scale;
    logic [2:0]          s_idx;

    assign pready = 1'b1;
    assign s_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_xw   <= RST_COS;
            r_sin_xw   <= RST_SIN;
            r_cos_yz   <= RST_COS;
            r_sin_yz   <= RST_SIN;
            r_center_x <= RST_CX;
            r_center_y <= RST_CY;
            r_scale    <= RST_SCALE;
        end else if (psel && penable && pwrite && pready) begin
            case (s_idx)
                REG_COS_XW:   r_cos_xw   <= pwdata[TRIG_W-1:0];
                REG_SIN_XW:   r_sin_xw   <= pwdata[TRIG_W-1:0];
                REG_COS_YZ:   r_cos_yz   <= pwdata[TRIG_W-1:0];
                REG_SIN_YZ:   r_sin_yz   <= pwdata[TRIG_W-1:0];
                REG_CENTER_X: r_center_x <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[CENTER_W-1:0];
                REG_SCALE:    r_scale    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_idx)
            REG_COS_XW:   prdata = 32'(r_cos_xw);
            REG_SIN_XW:   prdata = 32'(r_sin_xw);
            REG_COS_YZ:   prdata = 32'(r_cos_yz);
            REG_SIN_YZ:   prdata = 32'(r_sin_yz);
            REG_CENTER_X: prdata = 32'(r_center_x);
            REG_CENTER_Y: prdata = 32'(r_center_y);
            REG_SCALE:    prdata = 32'(r_scale);
            default:      prdata = '0;
        endcase
    end

    // Pipeline control.
    logic                s_en;
    logic [PIPE_LAT-1:0] r_v;

    assign s_en    = !(r_v[PIPE_LAT-1] && i_stall);
    assign o_stall = !s_en;
    assign o_valid = r_v[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (s_en) begin
            r_v <= {r_v[PIPE_LAT-2:0], i_valid};
        end
    end

    // Stage 1: rotation products.
    logic signed [TRIG_W-1:0] s_c1, s_s1, s_c2, s_s2;
    logic signed [PROD_W-1:0] r_xc1, r_ws1, r_xs1, r_wc1, r_yc2, r_zs2, r_ys2, r_zc2;
    logic                     r1_last;

    assign s_c1 = $signed(r_cos_xw);
    assign s_s1 = $signed(r_sin_xw);
    assign s_c2 = $signed(r_cos_yz);
    assign s_s2 = $signed(r_sin_yz);

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_xc1   <= i_vx * s_c1;
            r_ws1   <= i_vw * s_s1;
            r_xs1   <= i_vx * s_s1;
            r_wc1   <= i_vw * s_c1;
            r_yc2   <= i_vy * s_c2;
            r_zs2   <= i_vz * s_s2;
            r_ys2   <= i_vy * s_s2;
            r_zc2   <= i_vz * s_c2;
            r1_last <= i_last_vertex;
        end
    end

    // Stage 2: rotated coordinates with 27 fraction bits.
    logic signed [ROT_W-1:0] r_nx, r_ny, r_nz, r_nw;
    logic                    r2_last;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_nx    <= ROT_W'(r_xc1) - ROT_W'(r_ws1);
            r_nw    <= ROT_W'(r_xs1) + ROT_W'(r_wc1);
            r_ny    <= ROT_W'(r_yc2) - ROT_W'(r_zs2);
            r_nz    <= ROT_W'(r_ys2) + ROT_W'(r_zc2);
            r2_last <= r1_last;
        end
    end

    // Stage 3: folded divisor, visibility and numerator magnitudes.
    logic signed [D1_W-1:0]  s_d1;
    logic signed [D2W_W-1:0] s_d2;
    logic signed [DEN_W:0]   s_nx3, s_ny3, s_nx3n, s_ny3n;
    logic [DEN_W-1:0]        r3_d2;
    logic [MAG_W-1:0]        r3_mx, r3_my;
    t_side                   r3_side;

    always_comb begin
        s_d1   = W_DIST_FIX - D1_W'(r_nw);
        s_d2   = (D2W_W'(s_d1) <<< 2) - (D2W_W'(r_nz) <<< 1) - D2W_W'(r_nz);
        s_nx3  = ((DEN_W+1)'(r_nx) <<< 1) + (DEN_W+1)'(r_nx);
        s_ny3  = ((DEN_W+1)'(r_ny) <<< 1) + (DEN_W+1)'(r_ny);
        s_nx3n = -s_nx3;
        s_ny3n = -s_ny3;
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r3_d2          <= s_d2[DEN_W-1:0];
            r3_mx          <= r_nx[ROT_W-1] ? s_nx3n[MAG_W-1:0] : s_nx3[MAG_W-1:0];
            r3_my          <= r_ny[ROT_W-1] ? s_ny3n[MAG_W-1:0] : s_ny3[MAG_W-1:0];
            r3_side.last   <= r2_last;
            r3_side.behind <= (s_d1 <= 0) || (s_d2 <= 0);
            r3_side.neg_x  <= r_nx[ROT_W-1];
            r3_side.neg_y  <= r_ny[ROT_W-1];
            r3_side.ovf_x  <= 1'b0;
            r3_side.ovf_y  <= 1'b0;
        end
    end

    // Stage 4: numerator magnitudes times the screen scale.
    logic [MUL_W-1:0] r4_px, r4_py;
    logic [DEN_W-1:0] r4_d2;
    t_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r4_px   <= MUL_W'(r3_mx) * MUL_W'(r_scale);
            r4_py   <= MUL_W'(r3_my) * MUL_W'(r_scale);
            r4_d2   <= r3_d2;
            r4_side <= r3_side;
        end
    end

    // Stage 5: rounding numerator, doubled divisor and quotient overflow check.
    logic [NUM_W-1:0] s_numx, s_numy, r5_numx, r5_numy;
    logic [DIV_W-1:0] s_den, r5_den;
    t_side            n5_side, r5_side;

    always_comb begin
        s_numx        = {r4_px, 1'b0} + NUM_W'(r4_d2);
        s_numy        = {r4_py, 1'b0} + NUM_W'(r4_d2);
        s_den         = {r4_d2, 1'b0};
        n5_side       = r4_side;
        n5_side.ovf_x = (DIV_W+QUOT_W)'(s_numx) >= {s_den, {QUOT_W{1'b0}}};
        n5_side.ovf_y = (DIV_W+QUOT_W)'(s_numy) >= {s_den, {QUOT_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r5_numx <= s_numx;
            r5_numy <= s_numy;
            r5_den  <= s_den;
            r5_side <= n5_side;
        end
    end

    // Divider stages.
    logic [QUOT_W-1:0] s_qx, s_qy;
    t_side             r_dside [DIV_STAGES];

    rp4d_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_num  (r5_numx),
        .i_den  (r5_den),
        .o_quot (s_qx)
    );

    rp4d_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (s_en),
        .i_num  (r5_numy),
        .i_den  (r5_den),
        .o_quot (s_qy)
    );

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_dside[0] <= r5_side;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dside[i] <= r_dside[i-1];
            end
        end
    end

    // Output stage: sign, centre offset, saturation, zero output for vertices behind the camera.
    t_side                    s_side;
    logic [QUOT_W-1:0]        s_qxs, s_qys;
    logic signed [SUM_W-1:0]  s_sumx, s_sumy;
    logic signed [SCREEN_W-1:0] n_sx, n_sy;
    logic signed [SCREEN_W-1:0] r_sx, r_sy;
    logic                     r_behind, r_last;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (SCREEN_W-1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 << (SCREEN_W-1));

    always_comb begin
        s_side = r_dside[DIV_STAGES-1];
        s_qxs  = s_side.ovf_x ? {QUOT_W{1'b1}} : s_qx;
        s_qys  = s_side.ovf_y ? {QUOT_W{1'b1}} : s_qy;
        s_sumx = SUM_W'({r_center_x, 4'b0});
        s_sumy = SUM_W'({r_center_y, 4'b0});
        s_sumx = s_side.neg_x ? s_sumx - SUM_W'(s_qxs) : s_sumx + SUM_W'(s_qxs);
        s_sumy = s_side.neg_y ? s_sumy + SUM_W'(s_qys) : s_sumy - SUM_W'(s_qys);
        if (s_sumx > SAT_MAX)      n_sx = SAT_MAX[SCREEN_W-1:0];
        else if (s_sumx < SAT_MIN) n_sx = SAT_MIN[SCREEN_W-1:0];
        else                       n_sx = s_sumx[SCREEN_W-1:0];
        if (s_sumy > SAT_MAX)      n_sy = SAT_MAX[SCREEN_W-1:0];
        else if (s_sumy < SAT_MIN) n_sy = SAT_MIN[SCREEN_W-1:0];
        else                       n_sy = s_sumy[SCREEN_W-1:0];
        if (s_side.behind) begin
            n_sx = '0;
            n_sy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_sx     <= n_sx;
            r_sy     <= n_sy;
            r_behind <= s_side.behind;
            r_last   <= s_side.last;
        end
    end

    assign o_screen_x      = r_sx;
    assign o_screen_y      = r_sy;
    assign o_behind_camera = r_behind;
    assign o_last_out      = r_last;

endmodule
